[hw/rtl/zero_dilation_3x3_window_top_assert.svh]
// Assertion macros shared by the RTL of the zero dilation window.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ZERO_DILATION_3X3_WINDOW_TOP_ASSERT_SVH
`define ZERO_DILATION_3X3_WINDOW_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZDW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZDW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/zdw_pkg.sv]
`default_nettype none

package zdw_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = COL_W + 1;

  // Fixed field widths.
  localparam int PIX_W   = 8;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_WINDOW_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // Window mode codes; the unused code behaves as the full block.
  localparam logic [1:0] MODE_HORIZ = 2'd0;
  localparam logic [1:0] MODE_VERT  = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  // Item kinds carried on tuser.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Register reset values and the smallest legal sizes.
  localparam logic [WID_W-1:0]    WIDTH_RESET  = WID_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [WID_W-1:0]    MIN_WIDTH    = WID_W'(3);
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = 16'd3;

  // One window column: top byte, middle byte, bottom byte.
  typedef logic [3*PIX_W-1:0] zdw_col_t;

  // Control and payload carried from the accept stage to the window stage.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] idx;
    logic             emit;
    logic             use_left;
    logic             use_right;
    logic             use_top;
    logic             use_bot;
    logic             last;
    logic             fwd;
  } zdw_stage_t;

  // True when this column holds a zero in one of the rows under test.
  function automatic logic col_hit(zdw_col_t c, logic rows, logic top, logic bot);
    logic hit;
    hit = (c[2*PIX_W-1:PIX_W] == '0);
    if (rows && top && (c[3*PIX_W-1:2*PIX_W] == '0)) hit = 1'b1;
    if (rows && bot && (c[PIX_W-1:0] == '0)) hit = 1'b1;
    return hit;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/zero_dilation_3x3_window_top.sv]
// A result goes from its accepted item through the window stage register to the output
// register; in stream position the output trails the input by one row and one pixel.
// Throughput: one item per cycle unless output stalls, set by the single line memory RMW.
// Reset (rst, synchronous, active high) clears counters, window and pipeline valids and
// restores the register defaults; the line memory is not cleared and needs no pass.
`default_nettype none

module zero_dilation_3x3_window_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Input stream.
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [zdw_pkg::PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel_in
  input  wire logic                       s_axis_tuser,   // [0] func
  // Output stream.
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [zdw_pkg::PIX_W-1:0]       m_axis_tdata,   // [7:0] pixel_out
  output logic                            m_axis_tlast,   // frame_last
  // Configuration writes.
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [zdw_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [zdw_pkg::CFG_W-1:0]  cfg_data
);

  localparam int COL_W    = zdw_pkg::COL_W;
  localparam int WID_W    = zdw_pkg::WID_W;
  localparam int HEIGHT_W = zdw_pkg::HEIGHT_W;
  localparam int PIX_W    = zdw_pkg::PIX_W;

  // Configuration registers, stored already clamped.
  logic [1:0]          window_mode;
  logic [WID_W-1:0]    width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [WID_W-1:0]    width_clamped;
  logic [HEIGHT_W-1:0] height_clamped;

  // Position counters.
  logic [COL_W-1:0]    in_col, in_col_next;
  logic [HEIGHT_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0]    out_col, out_col_next;
  logic [HEIGHT_W-1:0] out_row, out_row_next;

  // Accept stage decode.
  logic                s_fire;
  logic                row_pending;
  logic                drop;
  logic                emit;
  logic                col_end;
  logic                out_col_end;
  logic                bot;
  logic                last;
  logic [WID_W-1:0]    in_col_inc;
  logic [WID_W-1:0]    out_col_inc;
  logic [HEIGHT_W:0]   out_row_inc;
  logic [PIX_W-1:0]    pix;

  // Window stage.
  logic                    s1_valid;
  zdw_pkg::zdw_stage_t     s1;
  logic                    s1_fire;
  logic                    out_en;
  logic [2*PIX_W-1:0]      rd_q;
  logic [2*PIX_W-1:0]      fwd_q;
  logic [PIX_W-1:0]        up_v;
  logic [PIX_W-1:0]        lo_v;
  zdw_pkg::zdw_col_t       col_new;
  zdw_pkg::zdw_col_t       win_left;
  zdw_pkg::zdw_col_t       win_centre;
  logic                    use_rows;
  logic                    use_cols;
  logic                    hit;

  // Line memory: upper row in the high byte, lower row in the low byte.
  logic [2*PIX_W-1:0] line_mem [zdw_pkg::MAX_WIDTH];

  assign cfg_ready = 1'b1;

  // Clamp incoming sizes to the supported range.
  always_comb begin
    if (cfg_data[WID_W-1:0] > WID_W'(zdw_pkg::MAX_WIDTH)) begin
      width_clamped = WID_W'(zdw_pkg::MAX_WIDTH);
    end else if (cfg_data[WID_W-1:0] < zdw_pkg::MIN_WIDTH) begin
      width_clamped = zdw_pkg::MIN_WIDTH;
    end else begin
      width_clamped = cfg_data[WID_W-1:0];
    end
    height_clamped = (cfg_data < zdw_pkg::MIN_HEIGHT) ? zdw_pkg::MIN_HEIGHT : cfg_data;
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode <= zdw_pkg::MODE_BLOCK;
      width_eff   <= zdw_pkg::WIDTH_RESET;
      height_eff  <= zdw_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        zdw_pkg::REG_WINDOW_MODE:  window_mode <= cfg_data[1:0];
        zdw_pkg::REG_FRAME_WIDTH:  width_eff   <= width_clamped;
        zdw_pkg::REG_FRAME_HEIGHT: height_eff  <= height_clamped;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the window stage moves unless its result cannot enter the output register.
  assign out_en        = !m_axis_tvalid || m_axis_tready;
  assign s1_fire       = s1_valid && (!s1.emit || out_en);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Accept stage: classify the item and work out where it sits in the frame.
  always_comb begin
    row_pending = in_row < height_eff;
    drop        = (s_axis_tuser == zdw_pkg::FUNC_DRAIN) && row_pending;
    pix         = ((s_axis_tuser == zdw_pkg::FUNC_PIXEL) && row_pending) ? s_axis_tdata : '0;
    emit        = (in_row >= HEIGHT_W'(2)) || ((in_row == HEIGHT_W'(1)) && (in_col != '0));
    in_col_inc  = {1'b0, in_col} + WID_W'(1);
    out_col_inc = {1'b0, out_col} + WID_W'(1);
    out_row_inc = {1'b0, out_row} + (HEIGHT_W+1)'(1);
    col_end     = in_col_inc >= width_eff;
    out_col_end = out_col_inc >= width_eff;
    bot         = out_row_inc < {1'b0, height_eff};
    last        = !bot && out_col_end;
  end

  // Counter updates for an accepted item that is not ignored.
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (s_fire && !drop) begin
      if (col_end) begin
        in_col_next = '0;
        if (in_row != '1) in_row_next = in_row + HEIGHT_W'(1);
      end else begin
        in_col_next = in_col_inc[COL_W-1:0];
      end
      if (emit) begin
        if (last) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end else if (out_col_end) begin
          out_col_next = '0;
          out_row_next = out_row_inc[HEIGHT_W-1:0];
        end else begin
          out_col_next = out_col_inc[COL_W-1:0];
        end
      end
    end
  end

  // Counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // Window stage register; ignored drain items do not enter it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid && !drop;
    end
    if (s_fire) begin
      s1.pixel     <= pix;
      s1.idx       <= in_col;
      s1.emit      <= emit;
      s1.use_left  <= (in_col != COL_W'(1));
      s1.use_right <= (in_col != '0);
      s1.use_top   <= (out_row != '0);
      s1.use_bot   <= bot;
      s1.last      <= last;
      s1.fwd       <= s1_valid && (s1.idx == in_col);
      fwd_q        <= {lo_v, s1.pixel};
    end
  end

  // Line memory: read on accept, write back when the window stage moves.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      rd_q <= line_mem[in_col];
    end
    if (s1_fire) begin
      line_mem[s1.idx] <= {lo_v, s1.pixel};
    end
  end

  // Column assembly and zero test over the selected window.
  always_comb begin
    up_v     = s1.fwd ? fwd_q[2*PIX_W-1:PIX_W] : rd_q[2*PIX_W-1:PIX_W];
    lo_v     = s1.fwd ? fwd_q[PIX_W-1:0]       : rd_q[PIX_W-1:0];
    col_new  = {up_v, lo_v, s1.pixel};
    use_rows = (window_mode != zdw_pkg::MODE_HORIZ);
    use_cols = (window_mode != zdw_pkg::MODE_VERT);
    hit      = zdw_pkg::col_hit(win_centre, use_rows, s1.use_top, s1.use_bot);
    if (use_cols && s1.use_left &&
        zdw_pkg::col_hit(win_left, use_rows, s1.use_top, s1.use_bot)) begin
      hit = 1'b1;
    end
    if (use_cols && s1.use_right &&
        zdw_pkg::col_hit(col_new, use_rows, s1.use_top, s1.use_bot)) begin
      hit = 1'b1;
    end
  end

  // Window shift: the centre and left columns of the next position.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_centre <= '0;
    end else if (s1_fire) begin
      win_left   <= win_centre;
      win_centre <= col_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_fire && s1.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (s1_fire && s1.emit) begin
      m_axis_tdata <= hit ? '0 : win_centre[2*PIX_W-1:PIX_W];
      m_axis_tlast <= s1.last;
    end
  end

`include "zero_dilation_3x3_window_top_assert.svh"

  // Input stalls only behind a held result in both stages.
  `ZDW_ASSERT_SAME(a_stall_cause, !s_axis_tready, s1_valid && s1.emit && m_axis_tvalid, "input stalled without a blocked result")
  // An ignored drain item never occupies the window stage.
  `ZDW_ASSERT_NEXT(a_drop_skips, s_fire && drop, !s1_valid, "ignored drain entered the window stage")
  // The frame's final result returns every counter to the frame start.
  `ZDW_ASSERT_NEXT(a_frame_restart, s_fire && !drop && emit && last, (in_col == '0) && (in_row == '0) && (out_col == '0) && (out_row == '0), "counters not cleared at frame end")
  // A forwarded read always refers to the entry written by the item just ahead.
  `ZDW_ASSERT_SAME(a_fwd_same_entry, s1_valid && s1.fwd, s1.idx == $past(s1.idx), "forwarding for a different entry")

endmodule

`default_nettype wire

[dv/zdw_checker.sv]
`default_nettype none

module zdw_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  input  wire logic                        s_axis_tready,
  input  wire logic [zdw_pkg::PIX_W-1:0]   s_axis_tdata,
  input  wire logic                        s_axis_tuser,
  input  wire logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic [zdw_pkg::PIX_W-1:0]   m_axis_tdata,
  input  wire logic                        m_axis_tlast,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [zdw_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [zdw_pkg::CFG_W-1:0]   cfg_data,
  output int                               mismatches,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;
  localparam int PIX_W     = zdw_pkg::PIX_W;
  localparam int MAX_WIDTH = zdw_pkg::MAX_WIDTH;

  // One predicted output item.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } dilated_px_t;

  // Shadow copy of the registers and the datapath state.
  logic [1:0]                   mode_q;
  logic [11:0]                  width_q;
  logic [zdw_pkg::HEIGHT_W-1:0] height_q;
  logic [PIX_W-1:0]             store_up [MAX_WIDTH];
  logic [PIX_W-1:0]             store_lo [MAX_WIDTH];
  logic [3*PIX_W-1:0]           win [3];
  int unsigned                  in_col, in_row, out_col, out_row;

  dilated_px_t expected_pixels [$];
  dilated_px_t head;
  int          fail_tally;
  int          results_seen;

  initial begin
    mismatches = 0;
    pending    = 0;
    fail_tally = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_tally < PRINT_CAP) begin
      $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, what);
    end
    fail_tally++;
  endtask

  // Width and height after clamping to the legal range.
  function automatic int unsigned eff_width();
    if (width_q < 3) return 3;
    if (width_q > MAX_WIDTH) return MAX_WIDTH;
    return width_q;
  endfunction

  function automatic int unsigned eff_height();
    return (height_q < 3) ? 3 : height_q;
  endfunction

  // Zero test over the selected window; l and r are negative where the
  // neighbor column lies outside the frame.
  function automatic logic [PIX_W-1:0] window_test(input int l, input int c, input int r,
                                                   input logic top, input logic bot);
    logic               use_rows, use_cols, hit;
    logic [3*PIX_W-1:0] w;
    int                 cols [3];
    int                 n;
    use_rows = (mode_q != zdw_pkg::MODE_HORIZ);
    use_cols = (mode_q != zdw_pkg::MODE_VERT);
    cols[0] = c;
    n = 1;
    if (use_cols && l >= 0) begin
      cols[n] = l;
      n = n + 1;
    end
    if (use_cols && r >= 0) begin
      cols[n] = r;
      n = n + 1;
    end
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      w = win[cols[i]];
      if (w[15:8] == 8'd0) hit = 1'b1;
      if (use_rows && top && w[23:16] == 8'd0) hit = 1'b1;
      if (use_rows && bot && w[7:0] == 8'd0) hit = 1'b1;
    end
    return hit ? 8'd0 : win[c][15:8];
  endfunction

  // Advance the shadow datapath by one accepted input item.
  function automatic void predict_dilation(input logic func, input logic [PIX_W-1:0] px);
    int unsigned        w, h, ix, iy, idx;
    logic [PIX_W-1:0]   p, res;
    logic [3*PIX_W-1:0] col;
    logic               emit, top, bot, last;
    dilated_px_t        e;
    w = eff_width();
    h = eff_height();
    ix = in_col;
    iy = in_row;
    // A drain tick before the frame is complete does nothing.
    if (func == zdw_pkg::FUNC_DRAIN && iy < h) return;
    p = (func == zdw_pkg::FUNC_PIXEL && iy < h) ? px : 8'd0;
    idx = (ix < MAX_WIDTH) ? ix : 0;
    col = {store_up[idx], store_lo[idx], p};
    emit = (iy >= 2) || (iy == 1 && ix >= 1);
    top = (out_row != 0);
    bot = (out_row + 1 < h);
    res = 8'd0;
    // The last column is judged on the window before the shift.
    if (emit && ix == 0) res = window_test(1, 2, -1, top, bot);
    win[0] = win[1];
    win[1] = win[2];
    win[2] = col;
    if (emit && ix == 1) res = window_test(-1, 1, 2, top, bot);
    else if (emit && ix >= 2) res = window_test(0, 1, 2, top, bot);
    store_up[idx] = store_lo[idx];
    store_lo[idx] = p;
    // Input position, with the row saturating.
    if (ix + 1 >= w) begin
      in_col = 0;
      if (iy < 32'hFFFF) in_row = iy + 1;
    end else begin
      in_col = ix + 1;
    end
    if (!emit) return;
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    e.pixel = res;
    e.last = last;
    expected_pixels.push_back(e);
    // Output position; the frame end clears every counter.
    if (last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row = (out_row + 1) & 32'hFFFF;
    end else begin
      out_col = out_col + 1;
    end
  endfunction

  // Watch the three channels at every edge.
  always @(posedge clk) begin
    if (rst) begin
      mode_q = zdw_pkg::MODE_BLOCK;
      width_q = zdw_pkg::WIDTH_RESET;
      height_q = zdw_pkg::HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        store_up[i] = '0;
        store_lo[i] = '0;
      end
      for (int i = 0; i < 3; i++) win[i] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          zdw_pkg::REG_WINDOW_MODE:  mode_q = cfg_data[1:0];
          zdw_pkg::REG_FRAME_WIDTH:  width_q = cfg_data[11:0];
          zdw_pkg::REG_FRAME_HEIGHT: height_q = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_dilation(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected item pixel_out=%0d frame_last=%0b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          head = expected_pixels.pop_front();
          if (m_axis_tdata !== head.pixel)
            report_mismatch($sformatf("pixel_out=%0d, predicted %0d", m_axis_tdata,
                                      head.pixel));
          if (m_axis_tlast !== head.last)
            report_mismatch($sformatf("frame_last=%0b, predicted %0b", m_axis_tlast,
                                      head.last));
        end
        results_seen++;
      end
    end
    pending <= expected_pixels.size();
    mismatches <= fail_tally;
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W = zdw_pkg::PIX_W;
  localparam int IDX_W = zdw_pkg::IDX_W;
  localparam int CFG_W = zdw_pkg::CFG_W;

  // Index with no register behind it; writes there are dropped.
  localparam logic [IDX_W-1:0] REG_SPARE  = 2'd3;
  // Spare mode code, handled as the full block.
  localparam logic [1:0]       MODE_SPARE = 2'd3;
  localparam int SETTLE = 8;
  localparam int RANDOM_ITEMS = 1350;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  wire logic             s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;
  logic                  s_axis_tuser;
  wire logic             m_axis_tvalid;
  logic                  m_axis_tready;
  wire logic [PIX_W-1:0] m_axis_tdata;
  wire logic             m_axis_tlast;
  logic                  cfg_valid;
  wire logic             cfg_ready;
  logic [IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  int          pending;
  int          mismatches;
  int          burst_left;
  logic [15:0] rx_tick;

  // A 3x3 frame with zeros on an edge and in a corner, plus the
  // value extremes.
  logic [PIX_W-1:0] probe_px [9] = '{8'd255, 8'd1, 8'd0,
                                     8'd0, 8'd77, 8'd254,
                                     8'd128, 8'd255, 8'd200};

  zero_dilation_3x3_window_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  zdw_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("zero_dilation_3x3_window_top: mismatch");
    $finish;
  end

  // Receiver: cycles through always ready, mostly ready, a fixed duty
  // cycle and coin flips.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 16'd1;
    case (rx_tick[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_axis_tready <= (rx_tick % 5 < 2);
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Gray value with a chosen share of zeros.
  function automatic logic [PIX_W-1:0] pick_pixel(input int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 8'd0;
    case ($urandom_range(0, 5))
      0: return 8'd255;
      1: return 8'd1;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Send one item; the sender runs in bursts with idle gaps between them.
  task automatic push(input logic func, input logic [PIX_W-1:0] px);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  // Stop sending until every predicted item has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [CFG_W-1:0] wdata,
                           input logic [CFG_W-1:0] hdata);
    write_reg(zdw_pkg::REG_WINDOW_MODE, {14'd0, mode});
    write_reg(zdw_pkg::REG_FRAME_WIDTH, wdata);
    write_reg(zdw_pkg::REG_FRAME_HEIGHT, hdata);
  endtask

  // Push out the pending results; some of the ticks are pixels, whose value the
  // block ignores once the frame is in.
  task automatic flush_frame(input int count, input logic noisy);
    for (int i = 0; i < count; i++) begin
      if (noisy && $urandom_range(0, 4) == 0) begin
        push(zdw_pkg::FUNC_PIXEL, 8'($urandom_range(0, 255)));
      end else begin
        push(zdw_pkg::FUNC_DRAIN, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // One whole frame of w x h pixels and its drain. With noise, stray drain
  // ticks fall inside the frame and after its end, where they are ignored.
  task automatic run_frame(input int w, input int h, input int zero_pct, input logic noisy);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        push(zdw_pkg::FUNC_DRAIN, 8'($urandom_range(0, 255)));
      end
      push(zdw_pkg::FUNC_PIXEL, pick_pixel(zero_pct));
    end
    flush_frame(w + 1, noisy);
    if (noisy) repeat ($urandom_range(0, 2)) push(zdw_pkg::FUNC_DRAIN, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_probe();
    foreach (probe_px[i]) begin
      if (i == 4) push(zdw_pkg::FUNC_DRAIN, 8'hA5);
      push(zdw_pkg::FUNC_PIXEL, probe_px[i]);
    end
  endtask

  initial begin
    int w, h, sent;
    logic [1:0] mode;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = zdw_pkg::FUNC_PIXEL;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = zdw_pkg::REG_WINDOW_MODE;
    cfg_data = '0;
    rx_tick = '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the probe frame in the horizontal mode at sizes clamped up to
    // 3x3, then in the full block, with a pixel arriving in the drain phase.
    write_reg(REG_SPARE, 16'hFFFF);
    configure(zdw_pkg::MODE_HORIZ, 16'd0, 16'd1);
    send_probe();
    flush_frame(4, 1'b0);
    wait_drained();
    configure(zdw_pkg::MODE_BLOCK, 16'd3, 16'd3);
    send_probe();
    push(zdw_pkg::FUNC_PIXEL, 8'h5A);
    flush_frame(3, 1'b0);

    // Random frames, mostly small; sometimes back to back without a pause.
    sent = 0;
    w = 3;
    h = 3;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        mode = 2'($urandom_range(0, 3));
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
        h = $urandom_range(3, 6);
        configure(mode, 16'(w), 16'(h));
      end
      run_frame(w, h, $urandom_range(5, 40), 1'b1);
      sent += w * h + w + 1;
    end

    // Widest row: the width register takes only its low bits, and 4095
    // clamps to the line store size. One full row and two pixels give the
    // first result; the width then drops to 3 to finish the frame quickly.
    wait_drained();
    configure(MODE_SPARE, 16'hFFFF, 16'd3);
    repeat (zdw_pkg::MAX_WIDTH + 2) push(zdw_pkg::FUNC_PIXEL, pick_pixel(10));
    wait_drained();
    write_reg(zdw_pkg::REG_FRAME_WIDTH, 16'd3);
    repeat (4) push(zdw_pkg::FUNC_PIXEL, pick_pixel(10));
    flush_frame(4, 1'b0);

    // Tallest height, cut down to four rows after three rows are in.
    wait_drained();
    configure(zdw_pkg::MODE_VERT, 16'd4, 16'hFFFF);
    repeat (12) push(zdw_pkg::FUNC_PIXEL, pick_pixel(20));
    wait_drained();
    write_reg(zdw_pkg::REG_FRAME_HEIGHT, 16'd4);
    repeat (4) push(zdw_pkg::FUNC_PIXEL, pick_pixel(20));
    flush_frame(5, 1'b0);

    // Width cut from 8 to 5 while the first row is coming in.
    wait_drained();
    configure(zdw_pkg::MODE_HORIZ, 16'd8, 16'd4);
    repeat (2) push(zdw_pkg::FUNC_PIXEL, pick_pixel(20));
    wait_drained();
    write_reg(zdw_pkg::REG_FRAME_WIDTH, 16'd5);
    repeat (18) push(zdw_pkg::FUNC_PIXEL, pick_pixel(20));
    flush_frame(6, 1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("zero_dilation_3x3_window_top: match");
    end else begin
      $display("zero_dilation_3x3_window_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
